>>> design/i2e_pkg.sv
// Shared types, constants and lookup functions for the ISO 8601 timestamp
// to epoch converter. No dependencies.

package i2e_pkg;

  // Field accumulator width and its saturation limit
  localparam int VALUE_BITS = 12;
  localparam logic [VALUE_BITS-1:0] ACC_LIMIT = {VALUE_BITS{1'b1}};

  // Record queue between front and back
  localparam int QDEPTH    = 4;
  localparam int QPTR_BITS = $clog2(QDEPTH);

  // Day count width, enough for any 12-bit year
  localparam int DAYS_BITS = 20;

  // Configuration register indexes
  localparam logic CFG_MIN_YEAR = 1'b0;
  localparam logic CFG_MAX_YEAR = 1'b1;

  localparam logic [11:0] MIN_YEAR_RESET = 12'd2023;
  localparam logic [11:0] MAX_YEAR_RESET = 12'd2100;

  // Scanner phases
  localparam logic [3:0] PH_YEAR   = 4'd0;
  localparam logic [3:0] PH_MONTH  = 4'd1;
  localparam logic [3:0] PH_DAY    = 4'd2;
  localparam logic [3:0] PH_HOUR   = 4'd3;
  localparam logic [3:0] PH_MINUTE = 4'd4;
  localparam logic [3:0] PH_SECOND = 4'd5;
  localparam logic [3:0] PH_FRAC   = 4'd6;
  localparam logic [3:0] PH_ZULU   = 4'd7;
  localparam logic [3:0] PH_PLUS   = 4'd8;
  localparam logic [3:0] PH_END    = 4'd9;

  // Characters
  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_PLUS  = 8'h2b;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_Z     = 8'h5a;

  localparam logic [2:0] PLUS_LEN = 3'd6;

  // One parsed string, handed from front to back
  typedef struct packed {
    logic [VALUE_BITS-1:0] year;
    logic [VALUE_BITS-1:0] month;
    logic [VALUE_BITS-1:0] day;
    logic [VALUE_BITS-1:0] hour;
    logic [VALUE_BITS-1:0] minute;
    logic [VALUE_BITS-1:0] second;
    logic                  bad;
  } i2e_rec_t;

  // Separator that ends each of the first five numbers
  function automatic logic [7:0] sep_char(input logic [2:0] idx);
    case (idx)
      3'd0, 3'd1: sep_char = CH_MINUS;
      3'd2:       sep_char = CH_T;
      default:    sep_char = CH_COLON;
    endcase
  endfunction

  // Characters of the "+00:00" tail
  function automatic logic [7:0] plus_char(input logic [2:0] pos);
    case (pos)
      3'd0:       plus_char = CH_PLUS;
      3'd3:       plus_char = CH_COLON;
      default:    plus_char = CH_ZERO;
    endcase
  endfunction

  // Days in a month of a common year
  function automatic logic [4:0] month_len(input logic [3:0] m);
    case (m)
      4'd2:                   month_len = 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11: month_len = 5'd30;
      default:                month_len = 5'd31;
    endcase
  endfunction

  // Days before the first of a month in a common year
  function automatic logic [8:0] cum_days(input logic [3:0] m);
    case (m)
      4'd2:    cum_days = 9'd31;
      4'd3:    cum_days = 9'd59;
      4'd4:    cum_days = 9'd90;
      4'd5:    cum_days = 9'd120;
      4'd6:    cum_days = 9'd151;
      4'd7:    cum_days = 9'd181;
      4'd8:    cum_days = 9'd212;
      4'd9:    cum_days = 9'd243;
      4'd10:   cum_days = 9'd273;
      4'd11:   cum_days = 9'd304;
      4'd12:   cum_days = 9'd334;
      default: cum_days = 9'd0;
    endcase
  endfunction

endpackage

>>> design/iso8601_utc_to_epoch.sv
// Top level of the ISO 8601 UTC timestamp to epoch converter.
// Depends on i2e_pkg, i2e_front, i2e_queue and i2e_back.
//
//   channel  | handshake           | payload
//   ---------+---------------------+----------------------------------------
//   input    | s_tvalid / s_tready | s_tdata = char_code, s_tlast = last
//   output   | m_tvalid / m_tready | m_tdata = epoch_seconds, m_tuser = ok
//   config   | cfg_we              | cfg_index, cfg_data (min/max year)
//
// One character word is taken every cycle while the record queue has room;
// the scanner updates its state once per character. A result leaves through
// a four-stage evaluator that runs one record per cycle unless the output stalls.
// Reset clears the scanner, the record queue and the pipeline, and loads the
// year limits with 2023 and 2100. A stalled output holds the evaluator; up to
// four finished strings wait in the queue, and s_tready drops when it is full.

module iso8601_utc_to_epoch
  import i2e_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_code
  input  logic        s_tlast,   // last
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] epoch_seconds
  output logic        m_tuser,   // [0] ok
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [11:0] cfg_data
);

  logic     q_full, push, head_valid, pop_ready;
  i2e_rec_t push_rec, head_rec;

  i2e_front u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .q_full   (q_full),
    .push     (push),
    .push_rec (push_rec)
  );

  i2e_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_rec   (push_rec),
    .full       (q_full),
    .head_valid (head_valid),
    .pop_ready  (pop_ready),
    .head_rec   (head_rec)
  );

  i2e_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .head_valid (head_valid),
    .head_rec   (head_rec),
    .pop_ready  (pop_ready),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser)
  );

endmodule

>>> design/i2e_front.sv
// Character scanner: takes one character word per cycle while the queue has
// room and builds the six number fields and the tail state. Depends on i2e_pkg.

module i2e_front
  import i2e_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_code
  input  logic        s_tlast,   // last
  input  logic        q_full,
  output logic        push,
  output i2e_rec_t    push_rec
);

  logic [3:0]            phase, phase_next;
  logic [VALUE_BITS-1:0] fields [6];
  logic                  neg, neg_next;
  logic                  sgn, sgn_next;
  logic                  dig, dig_next;
  logic [2:0]            pos, pos_next;
  logic                  mal, mal_next;

  logic [VALUE_BITS-1:0] cur, val_next;
  logic                  val_we;
  logic [VALUE_BITS+3:0] prod;
  logic [7:0]            c;
  logic                  is_dig, is_spc, tail_c, tail_n, accept;

  assign c        = s_tdata;
  assign s_tready = !q_full;
  assign accept   = s_tvalid && s_tready;
  assign push     = accept && s_tlast;

  assign is_dig = (c >= CH_ZERO) && (c <= CH_NINE);
  assign is_spc = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  assign tail_c = (phase == PH_ZULU) || (phase == PH_END) ||
                  ((phase == PH_PLUS) && (pos == PLUS_LEN));

  // Current field and its next decimal step, before saturation
  assign cur  = (phase <= PH_SECOND) ? fields[phase[2:0]] : '0;
  assign prod = ({4'b0, cur} << 3) + ({4'b0, cur} << 1) +
                (VALUE_BITS+4)'(c[3:0]);

  // Scan one character
  always_comb begin
    phase_next = phase;
    neg_next   = neg;
    sgn_next   = sgn;
    dig_next   = dig;
    pos_next   = pos;
    mal_next   = mal;
    val_next   = cur;
    val_we     = 1'b0;
    if (!mal) begin
      if (c == CH_NUL) begin
        if (tail_c) phase_next = PH_END;
        else mal_next = 1'b1;
      end else begin
        unique case (phase) inside
          PH_YEAR, PH_MONTH, PH_DAY, PH_HOUR, PH_MINUTE, PH_SECOND: begin
            if (!dig) begin
              if (!sgn && is_spc) begin
                // skip leading whitespace
              end else if (!sgn && ((c == CH_PLUS) || (c == CH_MINUS))) begin
                sgn_next = 1'b1;
                neg_next = (c == CH_MINUS);
              end else if (is_dig) begin
                dig_next = 1'b1;
                val_we   = 1'b1;
                val_next = VALUE_BITS'(c[3:0]);
              end else begin
                mal_next = 1'b1;
              end
            end else if (is_dig) begin
              val_we   = 1'b1;
              val_next = (prod > {4'b0, ACC_LIMIT}) ? ACC_LIMIT : prod[VALUE_BITS-1:0];
            end else if (neg && (cur != '0)) begin
              mal_next = 1'b1;
            end else if (phase != PH_SECOND) begin
              if (c == sep_char(phase[2:0])) begin
                phase_next = phase + 4'd1;
                dig_next   = 1'b0;
                sgn_next   = 1'b0;
                neg_next   = 1'b0;
              end else begin
                mal_next = 1'b1;
              end
            end else if (c == CH_DOT) begin
              phase_next = PH_FRAC;
              dig_next   = 1'b0;
            end else if (c == CH_Z) begin
              phase_next = PH_ZULU;
            end else if (c == CH_PLUS) begin
              phase_next = PH_PLUS;
              pos_next   = 3'd1;
            end else begin
              mal_next = 1'b1;
            end
          end
          PH_FRAC: begin
            if (is_dig) begin
              dig_next = 1'b1;
            end else if (dig && (c == CH_Z)) begin
              phase_next = PH_ZULU;
            end else if (dig && (c == CH_PLUS)) begin
              phase_next = PH_PLUS;
              pos_next   = 3'd1;
            end else begin
              mal_next = 1'b1;
            end
          end
          PH_PLUS: begin
            if ((pos < PLUS_LEN) && (c == plus_char(pos))) pos_next = pos + 3'd1;
            else mal_next = 1'b1;
          end
          PH_END: begin
            // text already ended
          end
          default: mal_next = 1'b1;
        endcase
      end
    end
  end

  assign tail_n = (phase_next == PH_ZULU) || (phase_next == PH_END) ||
                  ((phase_next == PH_PLUS) && (pos_next == PLUS_LEN));

  // Build the record from the state after this character
  always_comb begin
    push_rec.year   = (val_we && phase == PH_YEAR)   ? val_next : fields[0];
    push_rec.month  = (val_we && phase == PH_MONTH)  ? val_next : fields[1];
    push_rec.day    = (val_we && phase == PH_DAY)    ? val_next : fields[2];
    push_rec.hour   = (val_we && phase == PH_HOUR)   ? val_next : fields[3];
    push_rec.minute = (val_we && phase == PH_MINUTE) ? val_next : fields[4];
    push_rec.second = (val_we && phase == PH_SECOND) ? val_next : fields[5];
    push_rec.bad    = mal_next || !tail_n;
  end

  // Advance the scanner; clear it after the last character
  always_ff @(posedge clk) begin
    if (rst || push) begin
      phase <= PH_YEAR;
      neg   <= 1'b0;
      sgn   <= 1'b0;
      dig   <= 1'b0;
      pos   <= 3'd0;
      mal   <= 1'b0;
      for (int i = 0; i < 6; i++) fields[i] <= '0;
    end else if (accept) begin
      phase <= phase_next;
      neg   <= neg_next;
      sgn   <= sgn_next;
      dig   <= dig_next;
      pos   <= pos_next;
      mal   <= mal_next;
      if (val_we) fields[phase[2:0]] <= val_next;
    end
  end

endmodule

>>> design/i2e_queue.sv
// Short record queue between the scanner and the evaluator.
// Depends on i2e_pkg.

module i2e_queue
  import i2e_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  i2e_rec_t push_rec,
  output logic     full,
  output logic     head_valid,
  input  logic     pop_ready,
  output i2e_rec_t head_rec
);

  i2e_rec_t             slots [QDEPTH];
  logic [QPTR_BITS-1:0] wr_ptr, rd_ptr;
  logic [QPTR_BITS:0]   count;
  logic                 do_push, do_pop;

  assign full       = (count == (QPTR_BITS+1)'(QDEPTH));
  assign head_valid = (count != '0);
  assign head_rec   = slots[rd_ptr];
  assign do_push    = push && !full;
  assign do_pop     = head_valid && pop_ready;

  // Hold records in order; track fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (QPTR_BITS+1)'(do_push) - (QPTR_BITS+1)'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slots[wr_ptr] <= push_rec;
  end

endmodule

>>> design/i2e_back.sv
// Evaluator pipeline: range checks, leap years, day count and the epoch
// multiply, plus the year limit registers. Depends on i2e_pkg.

module i2e_back
  import i2e_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [11:0] cfg_data,
  input  logic        head_valid,
  input  i2e_rec_t    head_rec,
  output logic        pop_ready,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,
  output logic        m_tuser
);

  typedef struct packed {
    i2e_rec_t   rec;
    logic [5:0] yq;   // year / 100
    logic [9:0] lp;   // leap years up to year - 1
  } s1_t;

  typedef struct packed {
    logic                 good;
    logic [DAYS_BITS-1:0] yd;
    logic [8:0]           cum;
    logic [4:0]           day;
    logic [4:0]           hour;
    logic [5:0]           minute;
    logic [5:0]           second;
  } s2_t;

  typedef struct packed {
    logic                 good;
    logic [DAYS_BITS-1:0] days;
    logic [16:0]          hms;
  } s3_t;

  logic [11:0] min_year, max_year;
  logic        adv;
  logic        s1_valid, s2_valid, s3_valid;
  s1_t         s1, s1_in;
  s2_t         s2, s2_in;
  s3_t         s3, s3_in;
  logic [31:0] epoch_in;

  assign adv       = !m_tvalid || m_tready;
  assign pop_ready = adv;

  // Year limit registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_year <= MIN_YEAR_RESET;
      max_year <= MAX_YEAR_RESET;
    end else if (cfg_we) begin
      if (cfg_index == CFG_MIN_YEAR) min_year <= cfg_data;
      if (cfg_index == CFG_MAX_YEAR) max_year <= cfg_data;
    end
  end

  // Stage 1: divide the year by 100 through a reciprocal multiply, count leap years
  always_comb begin
    logic [VALUE_BITS-1:0] ym1;
    logic [VALUE_BITS+10:0] py, pm;
    logic [5:0] qm;
    ym1      = head_rec.year - 1'b1;
    py       = head_rec.year[VALUE_BITS-1:2] * 13'd5243;
    pm       = ym1[VALUE_BITS-1:2] * 13'd5243;
    qm       = pm[22:17];
    s1_in.rec = head_rec;
    s1_in.yq  = py[22:17];
    s1_in.lp  = ym1[VALUE_BITS-1:2] - 10'(qm) + 10'(qm[5:2]);
  end

  // Stage 2: leap year, range checks, month offset, whole-year days
  always_comb begin
    logic        leap;
    logic [12:0] hund;
    logic [5:0]  lim;
    logic [20:0] yrs;
    logic [3:0]  mo;
    hund = 13'(s1.yq) * 13'd100;
    leap = (s1.rec.year[1:0] == 2'b00) &&
           ((hund != 13'(s1.rec.year)) || (s1.yq[1:0] == 2'b00));
    mo   = s1.rec.month[3:0];
    lim  = 6'(month_len(mo)) + 6'((mo == 4'd2) && leap);
    yrs  = 21'(s1.rec.year - 12'd1970) * 21'd365;
    s2_in.good = !s1.rec.bad &&
                 (s1.rec.year >= min_year) && (s1.rec.year <= max_year) &&
                 (s1.rec.month >= 12'd1) && (s1.rec.month <= 12'd12) &&
                 (s1.rec.day >= 12'd1) && (s1.rec.day <= 12'(lim)) &&
                 (s1.rec.hour <= 12'd23) && (s1.rec.minute <= 12'd59) &&
                 (s1.rec.second <= 12'd59);
    s2_in.cum  = cum_days(mo) + 9'((mo > 4'd2) && leap);
    s2_in.yd   = (s1.rec.year > 12'd1970) ?
                 DAYS_BITS'(yrs) + DAYS_BITS'(s1.lp) - DAYS_BITS'(477) : '0;
    s2_in.day    = s1.rec.day[4:0];
    s2_in.hour   = s1.rec.hour[4:0];
    s2_in.minute = s1.rec.minute[5:0];
    s2_in.second = s1.rec.second[5:0];
  end

  // Stage 3: total days and seconds within the day
  always_comb begin
    s3_in.good = s2.good;
    s3_in.days = s2.yd + DAYS_BITS'(s2.cum) + DAYS_BITS'(s2.day) - DAYS_BITS'(1);
    s3_in.hms  = 17'(s2.hour) * 17'd3600 + 17'(s2.minute) * 17'd60 + 17'(s2.second);
  end

  // Stage 4: scale days to seconds, add the time of day, keep the low 32 bits
  always_comb begin
    logic [DAYS_BITS+16:0] dsec;
    dsec     = s3.days * 17'd86400;
    epoch_in = s3.good ? (dsec[31:0] + 32'(s3.hms)) : 32'd0;
  end

  // Advance the whole pipeline when the output register can take a word
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (adv) begin
      s1_valid <= head_valid;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      m_tvalid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1      <= s1_in;
      s2      <= s2_in;
      s3      <= s3_in;
      m_tdata <= epoch_in;
      m_tuser <= s3.good;
    end
  end

endmodule
